@@ rtl/linear_probe_hash_table_unit_assert.svh @@
// assertion macros for the hash table unit
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// property checked on every clock edge out of reset
`define LPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define LPHT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/lpht_pkg.sv @@
package lpht_pkg;

  localparam int unsigned SLOTS = 128;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_REMOVE = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_UPDATED = 3'd1,
    ST_FOUND   = 3'd2,
    ST_MISSING = 3'd3,
    ST_REMOVED = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CHECK = 2'd1,
    S_EMIT  = 2'd2
  } state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } ram_wr_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } ram_rd_t;

endpackage

@@ rtl/linear_probe_hash_table_unit.sv @@
// open-addressed key/value table, 128 slots, linear probing from key mod 128
// in_*  : one word per operation; in_tuser holds the operation
//         (insert, search, remove), in_tdata the key and the value
// out_* : one word per operation: status and hit in out_tuser,
//         the value found by a search in out_tdata (zero otherwise)
// an operation that probes k slots (1 to 128) walks them in S_CHECK, one
// key/value memory entry per cycle, then waits in S_EMIT until its word is
// loaded into the output register; the next operation can be accepted once
// the unit is back in S_IDLE
// a full circuit without a stop reports table full or not found
// one operation is in flight at a time; in_tready rises again once the
// result has moved into the output register, so a waiting result does not
// hold back the next operation
// when the receiver stalls the result stays in the output register and the
// next finished result waits in the unit until the register frees
// reset empties the table at once (per-slot used bits); keys and values in
// memory are not cleared
module linear_probe_hash_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // lookup_key[30:0], entry_value[62:31], zero
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_value[31:0]
  output logic [3:0]  out_tuser   // status[2:0], hit[3]
);
  import lpht_pkg::*;

  ram_wr_t          ram_wr;
  ram_rd_t          ram_rd;
  logic [IDX_W-1:0] ram_rd_addr;
  status_t          status;
  logic             hit;
  logic [VAL_W-1:0] read_value;

  lpht_probe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_func     (func_t'(in_tuser)),
    .in_key      (in_tdata[KEY_W-1:0]),
    .in_value    (in_tdata[KEY_W+VAL_W-1:KEY_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (status),
    .out_hit     (hit),
    .out_value   (read_value),
    .ram_wr      (ram_wr),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd      (ram_rd)
  );

  lpht_kv_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (ram_rd_addr),
    .rd      (ram_rd)
  );

  assign out_tdata = read_value;
  assign out_tuser = {hit, status};

endmodule

@@ rtl/lpht_kv_ram.sv @@
module lpht_kv_ram (
  input  logic              clk,
  input  lpht_pkg::ram_wr_t wr,
  input  logic [lpht_pkg::IDX_W-1:0] rd_addr,
  output lpht_pkg::ram_rd_t rd
);
  import lpht_pkg::*;

  ram_rd_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= '{key: wr.key, value: wr.value};
    end
    rd <= mem[rd_addr];
  end

endmodule

@@ rtl/lpht_probe_ctrl.sv @@
module lpht_probe_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lpht_pkg::func_t            in_func,
  input  logic [lpht_pkg::KEY_W-1:0] in_key,
  input  logic [lpht_pkg::VAL_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lpht_pkg::status_t          out_status,
  output logic                       out_hit,
  output logic [lpht_pkg::VAL_W-1:0] out_value,
  output lpht_pkg::ram_wr_t          ram_wr,
  output logic [lpht_pkg::IDX_W-1:0] ram_rd_addr,
  input  lpht_pkg::ram_rd_t          ram_rd
);
  import lpht_pkg::*;

  state_t           state_r, state_nxt;
  func_t            func_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] cnt_r;
  logic [SLOTS-1:0] used_r;
  logic             used_q_r;
  status_t          res_status_r;
  logic             res_hit_r;
  logic [VAL_W-1:0] res_val_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_val_r;

  logic             accept;
  logic             out_free;
  logic             empty;
  logic             match;
  logic             last;
  logic             stop;
  logic             used_set;
  logic             used_clr;
  status_t          res_status;
  logic             res_hit;
  logic [VAL_W-1:0] res_val;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign empty    = !used_q_r;
  assign match    = used_q_r && (ram_rd.key == key_r);
  assign last     = (cnt_r == IDX_W'(SLOTS - 1));

  // home slot is the key modulo the power-of-two table size
  assign ram_rd_addr = (state_r == S_IDLE) ? in_key[IDX_W-1:0] : pos_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stop) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    stop       = 1'b0;
    used_set   = 1'b0;
    used_clr   = 1'b0;
    res_status = ST_MISSING;
    res_hit    = 1'b0;
    res_val    = '0;
    ram_wr     = '{en: 1'b0, addr: pos_r, key: key_r, value: val_r};
    if (state_r == S_CHECK) begin
      case (func_r)
        FN_INSERT: begin
          stop = empty || match || last;
          if (match) begin
            ram_wr.en  = 1'b1;
            res_status = ST_UPDATED;
          end else if (empty) begin
            ram_wr.en  = 1'b1;
            used_set   = 1'b1;
            res_status = ST_NEW;
          end else begin
            res_status = ST_FULL;
          end
        end
        FN_SEARCH: begin
          stop = empty || match || last;
          if (match) begin
            res_status = ST_FOUND;
            res_hit    = 1'b1;
            res_val    = ram_rd.value;
          end
        end
        FN_REMOVE: begin
          stop = empty || match || last;
          if (match) begin
            used_clr   = 1'b1;
            res_status = ST_REMOVED;
          end
        end
        default: stop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (used_set) begin
        used_r[pos_r] <= 1'b1;
      end else if (used_clr) begin
        used_r[pos_r] <= 1'b0;
      end
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    used_q_r <= used_r[ram_rd_addr];
    if (accept) begin
      func_r <= in_func;
      key_r  <= in_key;
      val_r  <= in_value;
      pos_r  <= in_key[IDX_W-1:0];
      cnt_r  <= '0;
    end else if (state_r == S_CHECK && !stop) begin
      pos_r <= pos_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == S_CHECK && stop) begin
      res_status_r <= res_status;
      res_hit_r    <= res_hit;
      res_val_r    <= res_val;
    end
    if (state_r == S_EMIT && out_free) begin
      out_status_r <= res_status_r;
      out_hit_r    <= res_hit_r;
      out_val_r    <= res_val_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_hit    = out_hit_r;
  assign out_value  = out_val_r;

  `include "linear_probe_hash_table_unit_assert.svh"

  `LPHT_ASSERT(a_hit_is_found, out_valid_r |-> (out_hit_r == (out_status_r == ST_FOUND)), "hit without found")
  `LPHT_ASSERT(a_miss_zero, (out_valid_r && !out_hit_r) |-> (out_val_r == '0), "value on a miss")
  `LPHT_ASSERT(a_write_in_check, ram_wr.en |-> (state_r == S_CHECK && stop), "stray table write")
  `LPHT_ASSERT_NEXT(a_accept_probes, accept, state_r == S_CHECK && pos_r == $past(in_key[IDX_W-1:0]), "probe not at home slot")

endmodule
